>>> rtl/core/cpuag_pkg.sv
// Shared types and constants for the 65816-style address generation block.
// No dependencies; every other file in rtl/core imports this package.
package cpuag_pkg;

    // Field widths of the request and result beats.
    localparam int unsigned ADDR_W = 24;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned BANK_W = 8;
    localparam int unsigned MODE_W = 5;
    localparam int unsigned FB_W   = 2;

    // Beat kinds on the request channel.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_POINTER = 1'b1;

    // Program counter advance and pointer fetch sizes.
    localparam logic [1:0] ADV_ONE   = 2'd1;
    localparam logic [1:0] ADV_TWO   = 2'd2;
    localparam logic [1:0] ADV_THREE = 2'd3;
    localparam logic [FB_W-1:0] FETCH_NONE  = 2'd0;
    localparam logic [FB_W-1:0] FETCH_WORD  = 2'd2;
    localparam logic [FB_W-1:0] FETCH_LONG  = 2'd3;

    // Addressing modes; codes 21 to 31 are undefined.
    typedef enum logic [MODE_W-1:0] {
        MODE_IMM8        = 5'd0,
        MODE_IMM16       = 5'd1,
        MODE_ABS         = 5'd2,
        MODE_ABS_X       = 5'd3,
        MODE_ABS_Y       = 5'd4,
        MODE_LONG        = 5'd5,
        MODE_LONG_X      = 5'd6,
        MODE_ABS_IND     = 5'd7,
        MODE_ABS_X_IND   = 5'd8,
        MODE_DP          = 5'd9,
        MODE_DP_X        = 5'd10,
        MODE_DP_Y        = 5'd11,
        MODE_DP_IND      = 5'd12,
        MODE_DP_IND_LONG = 5'd13,
        MODE_DP_IND_Y    = 5'd14,
        MODE_DP_LONG_Y   = 5'd15,
        MODE_DP_X_IND    = 5'd16,
        MODE_REL8        = 5'd17,
        MODE_REL16       = 5'd18,
        MODE_SR          = 5'd19,
        MODE_SR_IND_Y    = 5'd20
    } t_mode;

    // One request beat as seen by the address logic.
    typedef struct packed {
        logic              kind;
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] operand_value;
        logic [WORD_W-1:0] program_counter;
        logic [BANK_W-1:0] data_bank;
        logic [WORD_W-1:0] direct_page;
        logic [WORD_W-1:0] index_x;
        logic [WORD_W-1:0] index_y;
        logic [WORD_W-1:0] stack_pointer;
        logic [ADDR_W-1:0] pointer_data;
    } t_req;

    // One result beat.
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              fetch_pointer;
        logic [FB_W-1:0]   fetch_bytes;
        logic [WORD_W-1:0] next_pc;
        logic              error;
    } t_res;

    // Indirect request waiting for its pointer data.
    typedef struct packed {
        logic              valid;
        logic [MODE_W-1:0] mode;
        logic [BANK_W-1:0] bank;
        logic [WORD_W-1:0] y;
    } t_pend;

endpackage

>>> rtl/core/cpuag_req_if.sv
// Request channel: valid/ready handshake with the request beat fields.
// Depends on cpuag_pkg for the field widths.
interface cpuag_req_if
    import cpuag_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] operand_value;
    logic [WORD_W-1:0] program_counter;
    logic [BANK_W-1:0] data_bank;
    logic [WORD_W-1:0] direct_page;
    logic [WORD_W-1:0] index_x;
    logic [WORD_W-1:0] index_y;
    logic [WORD_W-1:0] stack_pointer;
    logic [ADDR_W-1:0] pointer_data;

    modport source (
        output valid, kind, mode, operand_value, program_counter, data_bank,
               direct_page, index_x, index_y, stack_pointer, pointer_data,
        input  ready
    );

    modport sink (
        input  valid, kind, mode, operand_value, program_counter, data_bank,
               direct_page, index_x, index_y, stack_pointer, pointer_data,
        output ready
    );
endinterface

>>> rtl/core/cpuag_res_if.sv
// Result channel: valid/ready handshake with the result beat fields.
// Depends on cpuag_pkg for the field widths.
interface cpuag_res_if
    import cpuag_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic              fetch_pointer;
    logic [FB_W-1:0]   fetch_bytes;
    logic [WORD_W-1:0] next_pc;
    logic              error;

    modport source (
        output valid, address, fetch_pointer, fetch_bytes, next_pc, error,
        input  ready
    );

    modport sink (
        input  valid, address, fetch_pointer, fetch_bytes, next_pc, error,
        output ready
    );
endinterface

>>> rtl/core/cpuag_calc.sv
// Address computation for one beat: direct modes, pointer setup and
// pointer completion, plus the next pending-pointer state. Uses cpuag_pkg.
module cpuag_calc
    import cpuag_pkg::*;
(
    input  t_req  i_req,
    input  t_pend i_pend,
    output t_res  o_res,
    output t_pend o_pend
);

    logic [7:0]        op8;
    logic [WORD_W-1:0] op16;
    logic [WORD_W-1:0] dpa;
    logic [WORD_W-1:0] rel8_off;
    logic [ADDR_W-1:0] bank_op16;
    logic [ADDR_W-1:0] saved_p16;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        adv;
    logic [FB_W-1:0]   fb;
    logic              bad_mode;

    // Operand slices and the direct-page base shared by many modes.
    assign op8       = i_req.operand_value[7:0];
    assign op16      = i_req.operand_value[WORD_W-1:0];
    assign dpa       = i_req.direct_page + {8'd0, op8};
    assign rel8_off  = {{8{op8[7]}}, op8};
    assign bank_op16 = {i_req.data_bank, op16};
    assign saved_p16 = {i_pend.bank, i_req.pointer_data[WORD_W-1:0]};

    // Request decode: address, PC advance and pointer fetch size.
    always_comb begin
        addr     = '0;
        adv      = ADV_ONE;
        fb       = FETCH_NONE;
        bad_mode = 1'b0;
        case (t_mode'(i_req.mode))
            MODE_IMM8: begin
                addr = {16'd0, op8};
            end
            MODE_IMM16: begin
                addr = {8'd0, op16};
                adv  = ADV_TWO;
            end
            MODE_ABS: begin
                addr = bank_op16;
                adv  = ADV_TWO;
            end
            MODE_ABS_X: begin
                addr = bank_op16 + {8'd0, i_req.index_x};
                adv  = ADV_TWO;
            end
            MODE_ABS_Y: begin
                addr = bank_op16 + {8'd0, i_req.index_y};
                adv  = ADV_TWO;
            end
            MODE_LONG: begin
                addr = i_req.operand_value;
                adv  = ADV_THREE;
            end
            MODE_LONG_X: begin
                addr = i_req.operand_value + {8'd0, i_req.index_x};
                adv  = ADV_THREE;
            end
            MODE_ABS_IND: begin
                addr = {8'd0, op16};
                adv  = ADV_TWO;
                fb   = FETCH_WORD;
            end
            MODE_ABS_X_IND: begin
                addr = {8'd0, op16 + i_req.index_x};
                adv  = ADV_TWO;
                fb   = FETCH_WORD;
            end
            MODE_DP: begin
                addr = {8'd0, dpa};
            end
            MODE_DP_X: begin
                addr = {8'd0, dpa + i_req.index_x};
            end
            MODE_DP_Y: begin
                addr = {8'd0, dpa + i_req.index_y};
            end
            MODE_DP_IND, MODE_DP_IND_Y: begin
                addr = {8'd0, dpa};
                fb   = FETCH_WORD;
            end
            MODE_DP_IND_LONG, MODE_DP_LONG_Y: begin
                addr = {8'd0, dpa};
                fb   = FETCH_LONG;
            end
            MODE_DP_X_IND: begin
                addr = {8'd0, dpa + i_req.index_x};
                fb   = FETCH_WORD;
            end
            MODE_REL8: begin
                addr = {8'd0, i_req.program_counter + 16'd1 + rel8_off};
            end
            MODE_REL16: begin
                addr = {8'd0, i_req.program_counter + 16'd2 + op16};
                adv  = ADV_TWO;
            end
            MODE_SR: begin
                addr = {8'd0, i_req.stack_pointer + {8'd0, op8}};
            end
            MODE_SR_IND_Y: begin
                addr = {8'd0, i_req.stack_pointer + {8'd0, op8}};
                fb   = FETCH_WORD;
            end
            default: begin
                bad_mode = 1'b1;
            end
        endcase
    end

    // Result selection and pending-pointer bookkeeping.
    always_comb begin
        o_res  = '0;
        o_pend = i_pend;
        if (i_req.kind == KIND_POINTER) begin
            o_pend.valid = 1'b0;
            if (!i_pend.valid) begin
                // Pointer data with nothing outstanding.
                o_res.error = 1'b1;
            end else begin
                case (t_mode'(i_pend.mode))
                    MODE_ABS_IND, MODE_ABS_X_IND: begin
                        o_res.address = {8'd0, i_req.pointer_data[WORD_W-1:0]};
                    end
                    MODE_DP_IND_LONG: begin
                        o_res.address = i_req.pointer_data;
                    end
                    MODE_DP_IND_Y, MODE_SR_IND_Y: begin
                        o_res.address = saved_p16 + {8'd0, i_pend.y};
                    end
                    MODE_DP_LONG_Y: begin
                        o_res.address = i_req.pointer_data + {8'd0, i_pend.y};
                    end
                    default: begin
                        o_res.address = saved_p16;
                    end
                endcase
            end
        end else if (bad_mode) begin
            // Undefined mode: flag it and drop any outstanding pointer.
            o_pend.valid  = 1'b0;
            o_res.next_pc = i_req.program_counter;
            o_res.error   = 1'b1;
        end else begin
            o_res.address       = addr;
            o_res.fetch_pointer = (fb != FETCH_NONE);
            o_res.fetch_bytes   = fb;
            o_res.next_pc       = i_req.program_counter + {14'd0, adv};
            o_pend.valid        = (fb != FETCH_NONE);
            if (fb != FETCH_NONE) begin
                o_pend.mode = i_req.mode;
                o_pend.bank = i_req.data_bank;
                o_pend.y    = i_req.index_y;
            end
        end
    end

endmodule

>>> rtl/core/cpu65816_address_generation.sv
// Top level of the 65816-style address generation block.
// Depends on cpuag_pkg, cpuag_req_if, cpuag_res_if and cpuag_calc.
//
// Usage:
//   i_req carries request beats (kind 0: mode, operand bytes, registers) and
//   pointer beats (kind 1: the word or long pointer read from memory).
//   o_res returns exactly one result beat for every accepted beat of either kind.
//   An indirect mode returns the pointer address with fetch_pointer set and
//   fetch_bytes of 2 or 3; the caller reads the pointer and sends it back as
//   a kind 1 beat, which yields the final address. A new request drops any
//   outstanding pointer; a pointer beat with nothing outstanding sets error.
// Timing:
//   The address is computed in the cycle a beat is accepted and registered
//   in the output stage, or in the skid register while a result is held.
//   One beat can be accepted every cycle while the skid register is empty:
//   cpuag_calc's adders and muxes sit between the request port and output register.
// Reset and stalls:
//   Reset clears the output stage and the outstanding pointer, and holds
//   i_req.ready low. When the receiver holds ready low, one further beat is
//   parked in a skid register; out of reset, i_req.ready drops only while
//   that skid register is occupied.
module cpu65816_address_generation
    import cpuag_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpuag_req_if.sink  i_req,
    cpuag_res_if.source o_res
);

    t_req  req;
    t_res  calc_res;
    t_pend calc_pend;
    t_pend r_pend;
    t_res  r_out;
    t_res  r_skid;
    logic  r_out_valid;
    logic  r_skid_valid;
    logic  in_fire;
    logic  out_fire;

    // Gather the request beat into one struct for the address logic.
    always_comb begin
        req.kind            = i_req.kind;
        req.mode            = i_req.mode;
        req.operand_value   = i_req.operand_value;
        req.program_counter = i_req.program_counter;
        req.data_bank       = i_req.data_bank;
        req.direct_page     = i_req.direct_page;
        req.index_x         = i_req.index_x;
        req.index_y         = i_req.index_y;
        req.stack_pointer   = i_req.stack_pointer;
        req.pointer_data    = i_req.pointer_data;
    end

    cpuag_calc u_calc (
        .i_req  (req),
        .i_pend (r_pend),
        .o_res  (calc_res),
        .o_pend (calc_pend)
    );

    // Handshakes: out of reset, the skid register being full is the only input stall.
    assign i_req.ready = i_rst_n && !r_skid_valid;
    assign in_fire     = i_req.valid && i_req.ready;
    assign out_fire    = r_out_valid && o_res.ready;

    // Outstanding pointer state, updated on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_fire) begin
            r_pend <= calc_pend;
        end
    end

    // Output register and skid register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Result payloads.
    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= calc_res;
            end
        end else if (in_fire) begin
            r_skid <= calc_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.address       = r_out.address;
    assign o_res.fetch_pointer = r_out.fetch_pointer;
    assign o_res.fetch_bytes   = r_out.fetch_bytes;
    assign o_res.next_pc       = r_out.next_pc;
    assign o_res.error         = r_out.error;

    // The skid register only fills behind a held result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat with no result in front");

    // An accepted pointer beat always closes the outstanding pointer.
    a_ptr_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_req.kind == KIND_POINTER) |=> !r_pend.valid)
        else $error("pointer beat left a pointer outstanding");

    // An accepted request opens a pointer exactly when it asks for a fetch.
    a_req_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_req.kind == KIND_REQUEST) |=>
            (r_pend.valid == $past(calc_res.fetch_pointer)))
        else $error("pending pointer disagrees with the fetch request");

    // Fetch flag and fetch size agree in every delivered result.
    a_fetch_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.fetch_pointer == (r_out.fetch_bytes != FETCH_NONE)))
        else $error("fetch flag and fetch size disagree");

    // An error result never asks for a pointer fetch.
    a_error_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error) |-> !r_out.fetch_pointer)
        else $error("error result requests a pointer fetch");

endmodule

>>> test/cpu65816_address_generation_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for cpu65816_address_generation: direct and random beats.
// Depends on cpuag_pkg, cpuag_req_if, cpuag_res_if and the block's top level.
module cpu65816_address_generation_test
    import cpuag_pkg::*;
    ;

    localparam int RANDOM_BEATS   = 1300;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SQUEEZE_AT     = 600;
    localparam int SQUEEZE_CYCLES = 150;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 5'd21;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 5'd31;

    // Tracks the pointer that the block holds and the results it owes.
    class addr_gen_tracker;
        t_res              owed_results[$];
        bit                ptr_outstanding = 1'b0;
        logic [MODE_W-1:0] held_mode = '0;
        logic [BANK_W-1:0] held_bank = '0;
        logic [WORD_W-1:0] held_y = '0;
        int beats_noted = 0;
        int mismatches = 0;
        int n_direct = 0;
        int n_fetch = 0;
        int n_completions = 0;
        int n_errors = 0;

        // Work out the result of one accepted beat and queue it.
        function void note_beat(input t_req b);
            t_res              r;
            logic [7:0]        op8;
            logic [WORD_W-1:0] op16;
            logic [WORD_W-1:0] dpa;
            logic [WORD_W-1:0] near;
            logic [ADDR_W-1:0] bank_base;
            logic [1:0]        adv;
            r = '0;
            op8 = b.operand_value[7:0];
            op16 = b.operand_value[15:0];
            dpa = b.direct_page + 16'(op8);
            bank_base = {b.data_bank, op16};
            adv = ADV_ONE;
            beats_noted++;
            if (b.kind == KIND_POINTER) begin
                if (!ptr_outstanding) begin
                    r.error = 1'b1;
                    n_errors++;
                end else begin
                    ptr_outstanding = 1'b0;
                    n_completions++;
                    case (held_mode)
                        MODE_ABS_IND, MODE_ABS_X_IND: begin
                            r.address = {8'h00, b.pointer_data[15:0]};
                        end
                        MODE_DP_IND_LONG: r.address = b.pointer_data;
                        MODE_DP_IND_Y, MODE_SR_IND_Y: begin
                            r.address = {held_bank, b.pointer_data[15:0]} + 24'(held_y);
                        end
                        MODE_DP_LONG_Y: r.address = b.pointer_data + 24'(held_y);
                        default: r.address = {held_bank, b.pointer_data[15:0]};
                    endcase
                end
                owed_results.push_back(r);
                return;
            end

            // A new request always drops an outstanding pointer.
            ptr_outstanding = 1'b0;
            case (b.mode)
                MODE_IMM8:   r.address = 24'(op8);
                MODE_IMM16: begin
                    r.address = 24'(op16);
                    adv = ADV_TWO;
                end
                MODE_ABS: begin
                    r.address = bank_base;
                    adv = ADV_TWO;
                end
                MODE_ABS_X: begin
                    r.address = bank_base + 24'(b.index_x);
                    adv = ADV_TWO;
                end
                MODE_ABS_Y: begin
                    r.address = bank_base + 24'(b.index_y);
                    adv = ADV_TWO;
                end
                MODE_LONG: begin
                    r.address = b.operand_value;
                    adv = ADV_THREE;
                end
                MODE_LONG_X: begin
                    r.address = b.operand_value + 24'(b.index_x);
                    adv = ADV_THREE;
                end
                MODE_ABS_IND: begin
                    r.address = 24'(op16);
                    r.fetch_bytes = FETCH_WORD;
                    adv = ADV_TWO;
                end
                MODE_ABS_X_IND: begin
                    near = op16 + b.index_x;
                    r.address = 24'(near);
                    r.fetch_bytes = FETCH_WORD;
                    adv = ADV_TWO;
                end
                MODE_DP: r.address = 24'(dpa);
                MODE_DP_X: begin
                    near = dpa + b.index_x;
                    r.address = 24'(near);
                end
                MODE_DP_Y: begin
                    near = dpa + b.index_y;
                    r.address = 24'(near);
                end
                MODE_DP_IND, MODE_DP_IND_Y: begin
                    r.address = 24'(dpa);
                    r.fetch_bytes = FETCH_WORD;
                end
                MODE_DP_IND_LONG, MODE_DP_LONG_Y: begin
                    r.address = 24'(dpa);
                    r.fetch_bytes = FETCH_LONG;
                end
                MODE_DP_X_IND: begin
                    near = dpa + b.index_x;
                    r.address = 24'(near);
                    r.fetch_bytes = FETCH_WORD;
                end
                MODE_REL8: begin
                    // The branch offset is a signed byte.
                    near = b.program_counter + 16'd1 + {{8{op8[7]}}, op8};
                    r.address = 24'(near);
                end
                MODE_REL16: begin
                    near = b.program_counter + 16'd2 + op16;
                    r.address = 24'(near);
                    adv = ADV_TWO;
                end
                MODE_SR: begin
                    near = b.stack_pointer + 16'(op8);
                    r.address = 24'(near);
                end
                MODE_SR_IND_Y: begin
                    near = b.stack_pointer + 16'(op8);
                    r.address = 24'(near);
                    r.fetch_bytes = FETCH_WORD;
                end
                default: r.error = 1'b1;
            endcase

            if (r.error) begin
                r.next_pc = b.program_counter;
                n_errors++;
            end else begin
                r.next_pc = b.program_counter + 16'(adv);
            end
            if (r.fetch_bytes != FETCH_NONE) begin
                r.fetch_pointer = 1'b1;
                ptr_outstanding = 1'b1;
                held_mode = b.mode;
                held_bank = b.data_bank;
                held_y = b.index_y;
                n_fetch++;
            end else if (!r.error) begin
                n_direct++;
            end
            owed_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [23:0] want, logic [23:0] seen);
            if (want !== seen) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
                mismatches++;
            end
        endfunction

        // Compare one accepted result beat with the oldest owed result.
        function void check_result(input t_res got);
            t_res want;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("address", want.address, got.address);
            compare_field("fetch_pointer", 24'(want.fetch_pointer), 24'(got.fetch_pointer));
            compare_field("fetch_bytes", 24'(want.fetch_bytes), 24'(got.fetch_bytes));
            compare_field("next_pc", 24'(want.next_pc), 24'(got.next_pc));
            compare_field("error", 24'(want.error), 24'(got.error));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;
    bit   holding = 1'b0;
    addr_gen_tracker tracker = new();

    cpuag_req_if req_ch ();
    cpuag_res_if res_ch ();

    cpu65816_address_generation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    always #10 i_clk = ~i_clk;

    // Cycle counter and watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: no progress, %0d results still owed", $time,
                     tracker.owed_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Stretches in which neither side starts a random idle.
    function automatic bit quiet_stretch();
        return ((cycle_count / 400) % 3) == 1;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (holding || quiet_stretch() || roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Zero, all ones, or random, within the given width.
    function automatic logic [23:0] pick_value(int width);
        logic [23:0] mask;
        int          roll;
        mask = 24'((32'd1 << width) - 32'd1);
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return mask;
        return 24'($urandom) & mask;
    endfunction

    function automatic t_req random_beat(logic kind, logic [MODE_W-1:0] mode);
        t_req b;
        b.kind = kind;
        b.mode = mode;
        b.operand_value = pick_value(ADDR_W);
        b.program_counter = 16'(pick_value(WORD_W));
        b.data_bank = 8'(pick_value(BANK_W));
        b.direct_page = 16'(pick_value(WORD_W));
        b.index_x = 16'(pick_value(WORD_W));
        b.index_y = 16'(pick_value(WORD_W));
        b.stack_pointer = 16'(pick_value(WORD_W));
        b.pointer_data = pick_value(ADDR_W);
        return b;
    endfunction

    // Offer one beat and wait for the handshake; called right after a rising edge.
    task automatic drive_beat(input t_req b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.kind            <= b.kind;
        req_ch.mode            <= b.mode;
        req_ch.operand_value   <= b.operand_value;
        req_ch.program_counter <= b.program_counter;
        req_ch.data_bank       <= b.data_bank;
        req_ch.direct_page     <= b.direct_page;
        req_ch.index_x         <= b.index_x;
        req_ch.index_y         <= b.index_y;
        req_ch.stack_pointer   <= b.stack_pointer;
        req_ch.pointer_data    <= b.pointer_data;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        tracker.note_beat(b);
    endtask

    // Result side: check accepted beats and stall at random, once for a long stretch.
    initial begin
        int   stall_left;
        int   roll;
        bit   squeezed;
        t_res got;
        stall_left = 0;
        squeezed = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (res_ch.valid && res_ch.ready) begin
                    got.address = res_ch.address;
                    got.fetch_pointer = res_ch.fetch_pointer;
                    got.fetch_bytes = res_ch.fetch_bytes;
                    got.next_pc = res_ch.next_pc;
                    got.error = res_ch.error;
                    tracker.check_result(got);
                end
                if (!squeezed && tracker.beats_noted >= SQUEEZE_AT) begin
                    squeezed = 1'b1;
                    holding = 1'b1;
                    stall_left = SQUEEZE_CYCLES;
                end else if (stall_left == 0 && !quiet_stretch()) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 15) stall_left = $urandom_range(1, 3);
                    else if (roll < 17) stall_left = $urandom_range(10, 40);
                end
                if (stall_left > 0) begin
                    res_ch.ready <= 1'b0;
                    stall_left--;
                end else begin
                    res_ch.ready <= 1'b1;
                    holding = 1'b0;
                end
            end
        end
    end

    // Stimulus: every mode with all fields at ones, then random sequences.
    initial begin
        t_mode ind_modes[8] = '{MODE_ABS_IND, MODE_ABS_X_IND, MODE_DP_IND, MODE_DP_IND_LONG,
                                MODE_DP_IND_Y, MODE_DP_LONG_Y, MODE_DP_X_IND, MODE_SR_IND_Y};
        t_mode dir_modes[13] = '{MODE_IMM8, MODE_IMM16, MODE_ABS, MODE_ABS_X, MODE_ABS_Y,
                                 MODE_LONG, MODE_LONG_X, MODE_DP, MODE_DP_X, MODE_DP_Y,
                                 MODE_REL8, MODE_REL16, MODE_SR};
        t_req b;
        int   issued;
        int   roll;

        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind <= KIND_REQUEST;
        req_ch.mode <= MODE_IMM8;
        req_ch.operand_value <= '0;
        req_ch.program_counter <= '0;
        req_ch.data_bank <= '0;
        req_ch.direct_page <= '0;
        req_ch.index_x <= '0;
        req_ch.index_y <= '0;
        req_ch.stack_pointer <= '0;
        req_ch.pointer_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All-ones operands and registers hit every wrap; some pointers are
        // completed, the rest are dropped by the following request.
        for (int m = MODE_IMM8; m <= MODE_SR_IND_Y; m++) begin
            b = '1;
            b.kind = KIND_REQUEST;
            b.mode = 5'(m);
            drive_beat(b);
            if (m == MODE_ABS_IND || m == MODE_DP_IND_LONG || m == MODE_DP_LONG_Y ||
                m == MODE_SR_IND_Y) begin
                b.kind = KIND_POINTER;
                drive_beat(b);
            end
        end
        b = '1;
        b.kind = KIND_REQUEST;
        b.mode = MODE_UNDEF_HI;
        drive_beat(b);
        b.kind = KIND_POINTER;
        drive_beat(b);

        // Mostly well-formed request and pointer pairs, with noise mixed in.
        issued = 0;
        while (issued < RANDOM_BEATS) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                drive_beat(random_beat(KIND_REQUEST, ind_modes[$urandom_range(0, 7)]));
                drive_beat(random_beat(KIND_POINTER, 5'($urandom)));
                issued += 2;
            end else if (roll < 80) begin
                drive_beat(random_beat(KIND_REQUEST, dir_modes[$urandom_range(0, 12)]));
                issued++;
            end else if (roll < 87) begin
                drive_beat(random_beat(KIND_REQUEST,
                                       5'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI))));
                issued++;
            end else if (roll < 93) begin
                drive_beat(random_beat(KIND_POINTER, 5'($urandom)));
                issued++;
            end else begin
                // An indirect request cut off by another request of any mode.
                drive_beat(random_beat(KIND_REQUEST, ind_modes[$urandom_range(0, 7)]));
                drive_beat(random_beat(KIND_REQUEST, 5'($urandom)));
                drive_beat(random_beat(KIND_POINTER, 5'($urandom)));
                issued += 3;
            end
        end
        req_ch.valid <= 1'b0;

        while (tracker.owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats: %0d direct addresses, %0d pointer fetches,",
                 tracker.beats_noted, tracker.n_direct, tracker.n_fetch);
        $display("%0d pointer completions, %0d error results, %0d mismatched fields.",
                 tracker.n_completions, tracker.n_errors, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
